// ===== src/fwq_pkg.sv =====
package fwq_pkg;

	localparam int WAIT_DEPTH_DEF     = 16;
	localparam int ADDR_BITS_DEF      = 48;
	localparam int THREAD_ID_BITS_DEF = 8;

	localparam int REQ_BITS    = 2;
	localparam int VALUE_BITS  = 32;
	localparam int STATUS_BITS = 3;
	localparam int COUNT_BITS  = 5;

	localparam logic [REQ_BITS-1:0] REQ_WAIT    = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_WAKE    = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_CANCEL  = 2'd2;
	localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;

	localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_FAULT    = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_MISMATCH = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_INTR     = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd5;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic append;
		logic remove;
		logic by_tid;
	} cell_ctl_t;

endpackage

// ===== src/fwq_cell.sv =====
module fwq_cell #(
	parameter int ADDR_BITS      = fwq_pkg::ADDR_BITS_DEF,
	parameter int THREAD_ID_BITS = fwq_pkg::THREAD_ID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fwq_pkg::cell_ctl_t        ctl,
	input  logic [ADDR_BITS-1:0]      key_addr,
	input  logic [THREAD_ID_BITS-1:0] key_tid,
	input  logic                      prev_valid,
	input  logic                      next_valid,
	input  logic [ADDR_BITS-1:0]      next_addr,
	input  logic [THREAD_ID_BITS-1:0] next_tid,
	input  logic                      hit_in,
	input  logic [THREAD_ID_BITS-1:0] hit_tid_in,
	output logic                      valid,
	output logic [ADDR_BITS-1:0]      addr,
	output logic [THREAD_ID_BITS-1:0] tid,
	output logic                      hit_out,
	output logic [THREAD_ID_BITS-1:0] hit_tid_out
);

	logic                      valid_q;
	logic [ADDR_BITS-1:0]      addr_q;
	logic [THREAD_ID_BITS-1:0] tid_q;
	logic                      match;
	logic                      shift;
	logic                      load;

	assign match = valid_q & (ctl.by_tid ? (tid_q == key_tid) : (addr_q == key_addr));
	// at and above the oldest hit, take the neighbor's entry
	assign shift = ctl.remove & (hit_in | match);
	// the first empty cell takes the new waiter
	assign load  = ctl.append & ~valid_q & prev_valid;

	assign hit_out     = hit_in | match;
	assign hit_tid_out = (match & ~hit_in) ? tid_q : hit_tid_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			addr_q <= next_addr;
			tid_q  <= next_tid;
		end else if (load) begin
			addr_q <= key_addr;
			tid_q  <= key_tid;
		end
	end

	assign valid = valid_q;
	assign addr  = addr_q;
	assign tid   = tid_q;

endmodule

// ===== src/futex_wait_queue.sv =====
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  req_type addr addr_ok thread_id
//                                           current_value expected_or_count
// result    out        out_valid / out_ready status woken_thread woken_count last
//
// one request at a time: the request is captured while idle, then executed in the EXEC state
// wait, cancel and unknown ops give one result; a wake releasing k waiters gives k + 1 results,
// one result per cycle while out_ready holds, since the cell row removes one entry per cycle
// a result held by out_ready low stalls execution; no new request until the last result
// reset empties the table at once through the per-cell valid flops, no clearing pass
module futex_wait_queue #(
	parameter int WAIT_DEPTH     = fwq_pkg::WAIT_DEPTH_DEF,
	parameter int ADDR_BITS      = fwq_pkg::ADDR_BITS_DEF,
	parameter int THREAD_ID_BITS = fwq_pkg::THREAD_ID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fwq_pkg::REQ_BITS-1:0]       req_type,
	input  logic [ADDR_BITS-1:0]               addr,
	input  logic                               addr_ok,
	input  logic [THREAD_ID_BITS-1:0]          thread_id,
	input  logic [fwq_pkg::VALUE_BITS-1:0]     current_value,
	input  logic [fwq_pkg::VALUE_BITS-1:0]     expected_or_count,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fwq_pkg::STATUS_BITS-1:0]    status,
	output logic [THREAD_ID_BITS-1:0]          woken_thread,
	output logic [fwq_pkg::COUNT_BITS-1:0]     woken_count,
	output logic                               last
);

	localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

	// controller states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// captured request
	logic [fwq_pkg::REQ_BITS-1:0]   req_q;
	logic [ADDR_BITS-1:0]           addr_q;
	logic                           ok_q;
	logic [THREAD_ID_BITS-1:0]      tid_q;
	logic [fwq_pkg::VALUE_BITS-1:0] cur_q;
	logic [fwq_pkg::VALUE_BITS-1:0] arg_q;
	logic [CNT_W-1:0]               woken_q;

	// result register
	logic                            out_valid_q;
	logic [fwq_pkg::STATUS_BITS-1:0] status_q;
	logic [THREAD_ID_BITS-1:0]       thread_q;
	logic [fwq_pkg::COUNT_BITS-1:0]  count_q;
	logic                            last_q;

	// cell row links; the entry past the end reads as empty
	logic                      chain_valid [WAIT_DEPTH+1];
	logic [ADDR_BITS-1:0]      chain_addr  [WAIT_DEPTH+1];
	logic [THREAD_ID_BITS-1:0] chain_tid   [WAIT_DEPTH+1];
	logic                      hit         [WAIT_DEPTH+1];
	logic [THREAD_ID_BITS-1:0] hit_tid     [WAIT_DEPTH+1];

	fwq_pkg::cell_ctl_t        ctl;
	logic                      fire;
	logic                      full;
	logic                      any_hit;
	logic                      value_eq;
	logic [fwq_pkg::STATUS_BITS-1:0] nx_status;
	logic [THREAD_ID_BITS-1:0]       nx_thread;
	logic [fwq_pkg::COUNT_BITS-1:0]  nx_count;
	logic                            nx_last;
	logic                            nx_woke;

	assign chain_valid[WAIT_DEPTH] = 1'b0;
	assign chain_addr[WAIT_DEPTH]  = '0;
	assign chain_tid[WAIT_DEPTH]   = '0;
	assign hit[0]                  = 1'b0;
	assign hit_tid[0]              = '0;

	for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
		logic prev_v;
		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = chain_valid[i-1];
		end

		fwq_cell #(
			.ADDR_BITS      (ADDR_BITS),
			.THREAD_ID_BITS (THREAD_ID_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key_addr    (addr_q),
			.key_tid     (tid_q),
			.prev_valid  (prev_v),
			.next_valid  (chain_valid[i+1]),
			.next_addr   (chain_addr[i+1]),
			.next_tid    (chain_tid[i+1]),
			.hit_in      (hit[i]),
			.hit_tid_in  (hit_tid[i]),
			.valid       (chain_valid[i]),
			.addr        (chain_addr[i]),
			.tid         (chain_tid[i]),
			.hit_out     (hit[i+1]),
			.hit_tid_out (hit_tid[i+1])
		);
	end

	assign in_ready = (state_q == ST_IDLE);
	// result register is free or drains this cycle
	assign fire     = (state_q == ST_EXEC) & (~out_valid_q | out_ready);
	// compacted table: the last cell holds an entry only when every cell does
	assign full     = chain_valid[WAIT_DEPTH-1];
	assign any_hit  = hit[WAIT_DEPTH];
	assign value_eq = (cur_q == arg_q);

	always_comb begin
		ctl        = '0;
		nx_status  = fwq_pkg::ST_OK;
		nx_thread  = '0;
		nx_count   = '0;
		nx_last    = 1'b1;
		nx_woke    = 1'b0;
		case (req_q)
			fwq_pkg::REQ_WAIT: begin
				if (!ok_q) begin
					nx_status = fwq_pkg::ST_FAULT;
				end else if (!value_eq) begin
					nx_status = fwq_pkg::ST_MISMATCH;
				end else if (full) begin
					nx_status = fwq_pkg::ST_FULL;
				end else begin
					ctl.append = fire;
				end
			end
			fwq_pkg::REQ_WAKE: begin
				if (!ok_q) begin
					nx_status = fwq_pkg::ST_FAULT;
				end else if ((fwq_pkg::VALUE_BITS'(woken_q) < arg_q) && any_hit) begin
					// release the oldest waiter on the address
					nx_thread  = hit_tid[WAIT_DEPTH];
					nx_last    = 1'b0;
					nx_woke    = 1'b1;
					ctl.remove = fire;
				end else begin
					nx_count = fwq_pkg::COUNT_BITS'(woken_q);
				end
			end
			fwq_pkg::REQ_CANCEL: begin
				ctl.by_tid = 1'b1;
				if (any_hit) begin
					nx_status  = fwq_pkg::ST_INTR;
					ctl.remove = fire;
				end
			end
			default: begin
				nx_status = fwq_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				state_q <= ST_EXEC;
			end else if (fire && nx_last) begin
				state_q <= ST_IDLE;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q   <= req_type;
			addr_q  <= addr;
			ok_q    <= addr_ok;
			tid_q   <= thread_id;
			cur_q   <= current_value;
			arg_q   <= expected_or_count;
			woken_q <= '0;
		end else if (fire && nx_woke) begin
			woken_q <= woken_q + CNT_W'(1);
		end
		if (fire) begin
			status_q <= nx_status;
			thread_q <= nx_thread;
			count_q  <= nx_count;
			last_q   <= nx_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign woken_thread = thread_q;
	assign woken_count  = count_q;
	assign last         = last_q;

endmodule

// ===== src/fwq_checker.sv =====
module fwq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [fwq_pkg::STATUS_BITS-1:0] status,
	input logic [fwq_pkg::COUNT_BITS-1:0]  woken_count,
	input logic                            last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	// released thread results are ok and carry no count
	a_nonfinal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == fwq_pkg::ST_OK && woken_count == '0)
		else $error("bad non-final result");

	// error results carry no count
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fwq_pkg::ST_OK |-> last && woken_count == '0)
		else $error("error result with count or not final");

endmodule

bind futex_wait_queue fwq_checker u_fwq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.woken_count (woken_count),
	.last        (last)
);
